// File: hw/rtl/prf_pkg.sv
// Shared constants, types and codes of the PNG adaptive row filter.
package prf_pkg;

  // Geometry of the row stores and the counters.
  localparam int MaxWidth   = 4096;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int WidthW     = 13;
  localparam int HeightW    = 16;
  localparam int PixelW     = 32;
  localparam int LaneCount  = 4;
  localparam int NumFilters = 5;
  localparam int CostW      = 22;
  localparam int CfgDataW   = 16;
  localparam int OutDepth   = 4;

  // Configuration register indexes.
  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  // Filter codes as they appear in the filter byte of a row.
  localparam logic [2:0] FiltNone  = 3'd0;
  localparam logic [2:0] FiltSub   = 3'd1;
  localparam logic [2:0] FiltUp    = 3'd2;
  localparam logic [2:0] FiltAvg   = 3'd3;
  localparam logic [2:0] FiltPaeth = 3'd4;

  typedef logic [7:0] byte_t;
  typedef byte_t [NumFilters-1:0] filt_bytes_t;
  typedef logic [CostW-1:0] cost_t;
  typedef cost_t [NumFilters-1:0] cost_arr_t;

  // One output word as it waits in the output queue.
  typedef struct packed {
    logic [2:0]        filter_type;
    logic [PixelW-1:0] residual_bytes;
    logic              row_start;
    logic              image_end;
  } res_word_t;

endpackage

// File: hw/rtl/prf_in_if.sv
// Input pixel channel.
interface prf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] pixel_bytes;

  modport source (output valid, output mode, output pixel_bytes, input ready);
  modport sink (input valid, input mode, input pixel_bytes, output ready);
endinterface

// File: hw/rtl/prf_out_if.sv
// Filtered pixel output channel.
interface prf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  filter_type;
  logic [31:0] residual_bytes;
  logic        row_start;
  logic        image_end;

  modport source (output valid, output filter_type, output residual_bytes,
                  output row_start, output image_end, input ready);
  modport sink (input valid, input filter_type, input residual_bytes,
                input row_start, input image_end, output ready);
endinterface

// File: hw/rtl/prf_cfg_if.sv
// Configuration write channel.
interface prf_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/png_adaptive_row_filter_core.sv
// PNG adaptive row filter (RGBA8, minimum sum of absolute residuals), top level.
// One word is accepted per clock at a sustained rate of one per cycle unless the output
// queue holds input off: each pixel takes one read and one write of the two row-store
// RAMs, and the four byte lanes evaluate all five filters in parallel. A word runs
// through three stages (store read, cost accumulation, emission) plus a four-entry
// output queue. A row is emitted while the next row arrives, one filtered pixel per
// pixel word; drain words flush the last row of an image. The row stores need no
// clearing after reset.
module png_adaptive_row_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  prf_in_if.sink      in_i,
  prf_out_if.source   out_o,
  prf_cfg_if.sink     cfg_i
);
  import prf_pkg::*;

  // Configuration.
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(1);
      height_q <= HeightW'(1);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgImageWidth) begin
        width_q <= cfg_i.data[WidthW-1:0];
      end else begin
        height_q <= cfg_i.data[HeightW-1:0];
      end
    end
  end

  assign w_eff = (width_q == '0) ? WidthW'(1) :
                 (width_q > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : width_q;
  assign h_eff = (height_q == '0) ? HeightW'(1) : height_q;

  // Stage 0: position tracking and the decision what a word does.
  logic [AddrW-1:0]   col_q;
  logic [HeightW-1:0] row_q;
  logic               pend_q;
  logic               acc, is_pix, drain_ok, s0_emit, s0_work, last_col, row_wrap;
  logic [HeightW-1:0] emit_row;
  logic [HeightW:0]   row_inc;

  assign acc      = in_i.valid && in_i.ready;
  assign is_pix   = !in_i.mode;
  assign drain_ok = in_i.mode && pend_q && (row_q == '0);
  assign s0_emit  = acc && (is_pix ? pend_q : drain_ok);
  assign s0_work  = acc && (is_pix || drain_ok);
  assign last_col = ({1'b0, col_q} + WidthW'(1)) >= w_eff;
  assign row_inc  = {1'b0, row_q} + (HeightW+1)'(1);
  assign row_wrap = row_inc >= {1'b0, h_eff};
  assign emit_row = (row_q == '0) ? h_eff - HeightW'(1) : row_q - HeightW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= 1'b0;
    end else if (s0_work) begin
      if (last_col) begin
        col_q <= '0;
        if (is_pix) begin
          pend_q <= 1'b1;
          row_q  <= row_wrap ? '0 : row_inc[HeightW-1:0];
        end else begin
          pend_q <= 1'b0;
        end
      end else begin
        col_q <= col_q + AddrW'(1);
      end
    end
  end

  // Stage 1 registers.
  logic               s1_v_q, s1_pix_q, s1_emit_q, s1_last_q, s1_upz_q, s1_prz_q;
  logic               s1_rs_q, s1_end_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [PixelW-1:0]  s1_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_emit_q <= 1'b0;
    end else begin
      s1_v_q    <= s0_work;
      s1_emit_q <= s0_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q  <= is_pix;
    s1_last_q <= last_col;
    s1_addr_q <= col_q;
    s1_px_q   <= in_i.pixel_bytes;
    s1_upz_q  <= (row_q == '0);
    s1_prz_q  <= (emit_row == '0);
    s1_rs_q   <= (col_q == '0);
    s1_end_q  <= (emit_row == h_eff - HeightW'(1)) && last_col;
  end

  // Row stores; the word in stage 1 writes, the word in stage 0 reads.
  logic              st_we;
  logic [PixelW-1:0] upper_rd, older_rd, upper_val, older_val;
  logic              fwd_v_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [PixelW-1:0] fwd_upper_q, fwd_older_q;

  assign st_we = s1_v_q && s1_pix_q;

  prf_ram #(.Width(PixelW), .Depth(MaxWidth)) u_upper_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_px_q),
    .raddr_i(col_q),
    .rdata_o(upper_rd)
  );

  prf_ram #(.Width(PixelW), .Depth(MaxWidth)) u_older_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(s1_addr_q),
    .wdata_i(upper_val),
    .raddr_i(col_q),
    .rdata_o(older_rd)
  );

  // Bypass for a write that landed in the cycle of the read (one-pixel rows).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= st_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q  <= s1_addr_q;
    fwd_upper_q <= s1_px_q;
    fwd_older_q <= upper_val;
  end

  assign upper_val = (fwd_v_q && fwd_addr_q == s1_addr_q) ? fwd_upper_q : upper_rd;
  assign older_val = (fwd_v_q && fwd_addr_q == s1_addr_q) ? fwd_older_q : older_rd;

  // Stage 1: cost of each filter over the four byte lanes.
  logic [PixelW-1:0] left_q, ul_q, up_px, prior_px;
  filt_bytes_t       lane_mag [LaneCount];
  cost_arr_t         cost_q, cost_sum, fin_q;
  logic              sel_v_q;
  logic [2:0]        best;
  logic [2:0]        pend_filt_q;

  assign up_px    = s1_upz_q ? '0 : upper_val;
  assign prior_px = s1_prz_q ? '0 : older_val;

  for (genvar l = 0; l < LaneCount; l++) begin : g_cost_lane
    prf_lane u_lane (
      .x_i  (s1_px_q[l*8 +: 8]),
      .a_i  (left_q[l*8 +: 8]),
      .b_i  (up_px[l*8 +: 8]),
      .c_i  (ul_q[l*8 +: 8]),
      .res_o(),
      .mag_o(lane_mag[l])
    );
  end

  // Merge: add the lane magnitudes into the running row costs.
  always_comb begin
    for (int f = 0; f < NumFilters; f++) begin
      cost_sum[f] = cost_q[f] + CostW'({2'b00, lane_mag[0][f]} + {2'b00, lane_mag[1][f]} +
                                       {2'b00, lane_mag[2][f]} + {2'b00, lane_mag[3][f]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q  <= '0;
      left_q  <= '0;
      ul_q    <= '0;
      sel_v_q <= 1'b0;
    end else begin
      sel_v_q <= st_we && s1_last_q;
      if (st_we) begin
        if (s1_last_q) begin
          cost_q <= '0;
          left_q <= '0;
          ul_q   <= '0;
        end else begin
          cost_q <= cost_sum;
          left_q <= s1_px_q;
          ul_q   <= up_px;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we && s1_last_q) begin
      fin_q <= cost_sum;
    end
  end

  // Filter choice for the row that just completed.
  prf_select u_select (
    .costs_i(fin_q),
    .best_o (best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_filt_q <= FiltNone;
    end else if (sel_v_q) begin
      pend_filt_q <= best;
    end
  end

  // Stage 2 registers.
  logic              s2_v_q, s2_emit_q, s2_last_q, s2_rs_q, s2_end_q;
  logic [PixelW-1:0] s2_raw_q, s2_prior_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q    <= 1'b0;
      s2_emit_q <= 1'b0;
    end else begin
      s2_v_q    <= s1_v_q;
      s2_emit_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_last_q  <= s1_last_q;
    s2_rs_q    <= s1_rs_q;
    s2_end_q   <= s1_end_q;
    s2_raw_q   <= upper_val;
    s2_prior_q <= prior_px;
  end

  // Stage 2: filter the emitted pixel with the chosen filter.
  logic [2*PixelW-1:0] emit_left_q;
  filt_bytes_t         emit_res [LaneCount];
  logic [PixelW-1:0]   residual;

  for (genvar l = 0; l < LaneCount; l++) begin : g_emit_lane
    prf_lane u_lane (
      .x_i  (s2_raw_q[l*8 +: 8]),
      .a_i  (emit_left_q[l*8 +: 8]),
      .b_i  (s2_prior_q[l*8 +: 8]),
      .c_i  (emit_left_q[PixelW + l*8 +: 8]),
      .res_o(emit_res[l]),
      .mag_o()
    );
    assign residual[l*8 +: 8] = emit_res[l][pend_filt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_left_q <= '0;
    end else if (s2_v_q) begin
      if (s2_last_q) begin
        emit_left_q <= '0;
      end else if (s2_emit_q) begin
        emit_left_q <= {s2_prior_q, s2_raw_q};
      end
    end
  end

  // Output queue; input is held off while the queue could overflow.
  res_word_t        q_mem [OutDepth];
  logic [1:0]       wr_ptr_q, rd_ptr_q;
  logic [2:0]       cnt_q;
  logic             push, pop;
  res_word_t        head;

  assign push = s2_emit_q;
  assign pop  = out_o.valid && out_o.ready;
  assign head = q_mem[rd_ptr_q];

  assign in_i.ready = (cnt_q + {2'b00, s1_emit_q} + {2'b00, s2_emit_q}) < 3'(OutDepth);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{filter_type: pend_filt_q, residual_bytes: residual,
                           row_start: s2_rs_q, image_end: s2_end_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, push} - {2'b00, pop};
    end
  end

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.filter_type    = head.filter_type;
  assign out_o.residual_bytes = head.residual_bytes;
  assign out_o.row_start      = head.row_start;
  assign out_o.image_end      = head.image_end;
endmodule

// File: hw/rtl/prf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prf_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hw/rtl/prf_lane.sv
// One byte lane: residuals of all five filters and their signed-byte magnitudes.
module prf_lane (
  input  prf_pkg::byte_t      x_i,
  input  prf_pkg::byte_t      a_i,
  input  prf_pkg::byte_t      b_i,
  input  prf_pkg::byte_t      c_i,
  output prf_pkg::filt_bytes_t res_o,
  output prf_pkg::filt_bytes_t mag_o
);
  import prf_pkg::*;

  logic signed [9:0] pa, pb, pc;
  logic [8:0]        avg_sum;
  byte_t             paeth;

  // Paeth distances, all relative to p = a + b - c.
  always_comb begin
    pa = $signed({2'b00, b_i}) - $signed({2'b00, c_i});
    pb = $signed({2'b00, a_i}) - $signed({2'b00, c_i});
    pc = $signed({2'b00, a_i}) + $signed({2'b00, b_i}) - $signed({1'b0, c_i, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      paeth = a_i;
    end else if (pb <= pc) begin
      paeth = b_i;
    end else begin
      paeth = c_i;
    end
  end

  assign avg_sum = {1'b0, a_i} + {1'b0, b_i};

  // Residuals modulo 256.
  assign res_o[FiltNone]  = x_i;
  assign res_o[FiltSub]   = x_i - a_i;
  assign res_o[FiltUp]    = x_i - b_i;
  assign res_o[FiltAvg]   = x_i - avg_sum[8:1];
  assign res_o[FiltPaeth] = x_i - paeth;

  // Magnitude of each residual read as a signed byte.
  always_comb begin
    for (int f = 0; f < NumFilters; f++) begin
      mag_o[f] = res_o[f][7] ? 8'(9'd256 - {1'b0, res_o[f]}) : res_o[f];
    end
  end
endmodule

// File: hw/rtl/prf_select.sv
// Picks the cheapest filter; ties go to the lower filter number.
module prf_select (
  input  prf_pkg::cost_arr_t costs_i,
  output logic [2:0]         best_o
);
  import prf_pkg::*;

  logic [2:0] w01, w23, wlo;
  cost_t      c01, c23, clo;

  // Pairwise tree; the left side always holds the lower number.
  always_comb begin
    w01 = (costs_i[FiltSub] < costs_i[FiltNone]) ? FiltSub : FiltNone;
    c01 = (costs_i[FiltSub] < costs_i[FiltNone]) ? costs_i[FiltSub] : costs_i[FiltNone];
    w23 = (costs_i[FiltAvg] < costs_i[FiltUp]) ? FiltAvg : FiltUp;
    c23 = (costs_i[FiltAvg] < costs_i[FiltUp]) ? costs_i[FiltAvg] : costs_i[FiltUp];
    wlo = (c23 < c01) ? w23 : w01;
    clo = (c23 < c01) ? c23 : c01;
    best_o = (costs_i[FiltPaeth] < clo) ? FiltPaeth : wlo;
  end
endmodule

// File: hw/rtl/prf_checker.sv
// Port-level checks of the row filter, bound to the top level.
module prf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_filter_i,
  input logic [31:0] out_res_i,
  input logic        cfg_ready_i
);
  import prf_pkg::*;

  // A word that waits keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // A word that waits keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_res_i) && $stable(out_filter_i))
    else $error("output payload changed while stalled");

  // Only real filter codes leave the block.
  a_filter_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_filter_i == FiltNone || out_filter_i == FiltSub ||
                     out_filter_i == FiltUp || out_filter_i == FiltAvg ||
                     out_filter_i == FiltPaeth))
    else $error("illegal filter code");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid straight after reset");

  // Configuration writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port stalled");
endmodule

bind png_adaptive_row_filter_core prf_checker u_prf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_filter_i(out_o.filter_type),
  .out_res_i   (out_o.residual_bytes),
  .cfg_ready_i (cfg_i.ready)
);

// File: tb/sv/png_adaptive_row_filter_core_test.sv
// Self-checking testbench of the PNG adaptive row filter core.
`timescale 1ns / 100ps

module png_adaptive_row_filter_core_test;
  import prf_pkg::*;

  typedef struct {
    bit        drain;
    bit [31:0] px;
  } pix_word_t;

  logic clk_i;
  logic rst_ni;

  prf_in_if  in_ch ();
  prf_out_if out_ch ();
  prf_cfg_if cfg_ch ();

  png_adaptive_row_filter_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Words waiting to be sent and filtered pixels expected back.
  pix_word_t pending_words[$];
  res_word_t expected_pixels[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  words_added = 0;
  bit  word_held = 0;
  bit  word_taken = 0;
  bit  no_idle = 0;
  bit  send_pause = 0;
  int  rx_hold_cycles = 0;
  pix_word_t held_word;

  // Predictor state.
  int unsigned     cur_width = 1;
  int unsigned     cur_height = 1;
  bit [31:0]       upper_row [MaxWidth];
  bit [31:0]       older_row [MaxWidth];
  bit [31:0]       left_px = 0;
  bit [31:0]       upper_left_px = 0;
  bit [63:0]       emit_neighbors = 0;
  int unsigned     cost_sum [NumFilters];
  logic [2:0]      chosen_filter = FiltNone;
  int unsigned     col_idx = 0;
  int unsigned     row_idx = 0;
  bit              row_waiting = 0;

  function automatic int unsigned eff_width();
    if (cur_width == 0) return 1;
    return (cur_width > MaxWidth) ? MaxWidth : cur_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cur_height == 0) ? 1 : cur_height;
  endfunction

  // Prediction of one byte lane for one filter.
  function automatic int lane_guess(logic [2:0] f, int a, int b, int c);
    int p, pa, pb, pc;
    case (f)
      FiltSub: return a;
      FiltUp: return b;
      FiltAvg: return (a + b) >> 1;
      FiltPaeth: begin
        p = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit [31:0] residual(logic [2:0] f, bit [31:0] x, bit [31:0] a,
                                         bit [31:0] b, bit [31:0] c);
    bit [31:0] r;
    for (int l = 0; l < LaneCount; l++) begin
      r[l*8 +: 8] = x[l*8 +: 8] - 8'(lane_guess(f, a[l*8 +: 8], b[l*8 +: 8], c[l*8 +: 8]));
    end
    return r;
  endfunction

  // Sum of the residual bytes' magnitudes taken as signed bytes.
  function automatic int unsigned magnitude(bit [31:0] v);
    int unsigned s = 0;
    int unsigned b;
    for (int l = 0; l < LaneCount; l++) begin
      b = v[l*8 +: 8];
      s += (b < 128) ? b : 256 - b;
    end
    return s;
  endfunction

  // Expected word for column x of the row that waits for emission.
  function automatic void emit_column(int unsigned x, bit last_col);
    int unsigned h = eff_height();
    int unsigned e = (row_idx == 0) ? h - 1 : row_idx - 1;
    bit [31:0]   raw = upper_row[x];
    bit [31:0]   prior = (e == 0) ? 32'd0 : older_row[x];
    res_word_t   r;
    r.filter_type = chosen_filter;
    r.residual_bytes = residual(chosen_filter, raw, emit_neighbors[31:0], prior,
                                emit_neighbors[63:32]);
    r.row_start = (x == 0);
    r.image_end = (e == h - 1) && last_col;
    expected_pixels = {expected_pixels, r};
    emit_neighbors = {prior, raw};
  endfunction

  // Advance the predictor by one accepted word.
  function automatic void filter_word(pix_word_t w);
    int unsigned wd = eff_width();
    int unsigned h = eff_height();
    int unsigned x = col_idx;
    bit          last_col = (x + 1 >= wd);
    bit [31:0]   up;
    int unsigned best;
    if (w.drain) begin
      if (!row_waiting || row_idx != 0) return;
      emit_column(x, last_col);
      if (last_col) begin
        col_idx = 0;
        row_waiting = 0;
        emit_neighbors = 0;
      end else begin
        col_idx = x + 1;
      end
      return;
    end
    up = (row_idx == 0) ? 32'd0 : upper_row[x];
    if (row_waiting) emit_column(x, last_col);
    for (int f = 0; f < NumFilters; f++) begin
      cost_sum[f] += magnitude(residual(3'(f), w.px, left_px, up, upper_left_px));
    end
    older_row[x] = upper_row[x];
    upper_row[x] = w.px;
    left_px = w.px;
    upper_left_px = up;
    if (last_col) begin
      best = 0;
      for (int f = 1; f < NumFilters; f++) begin
        if (cost_sum[f] < cost_sum[best]) best = f;
      end
      chosen_filter = 3'(best);
      row_waiting = 1;
      for (int f = 0; f < NumFilters; f++) cost_sum[f] = 0;
      left_px = 0;
      upper_left_px = 0;
      emit_neighbors = 0;
      col_idx = 0;
      row_idx = (row_idx + 1 >= h) ? 0 : row_idx + 1;
    end else begin
      col_idx = x + 1;
    end
  endfunction

  // Input acceptance, output checking and the cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      filter_word(held_word);
      word_taken = 1;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: type %0d res %h start %b end %b", out_ch.filter_type,
                   out_ch.residual_bytes, out_ch.row_start, out_ch.image_end);
        end
      end else begin
        res_word_t e;
        e = expected_pixels.pop_front();
        if (out_ch.filter_type !== e.filter_type || out_ch.residual_bytes !== e.residual_bytes ||
            out_ch.row_start !== e.row_start || out_ch.image_end !== e.image_end) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected type %0d res %h start %b end %b, got %0d %h %b %b",
                     e.filter_type, e.residual_bytes, e.row_start, e.image_end,
                     out_ch.filter_type, out_ch.residual_bytes, out_ch.row_start,
                     out_ch.image_end);
          end
        end
      end
    end
  end

  // Sender: offers the next word at the falling edge, idling at random.
  always @(negedge clk_i) begin
    if (word_taken) begin
      word_taken = 0;
      word_held = 0;
    end
    if (!word_held && !send_pause && pending_words.size() > 0 &&
        (no_idle || $urandom_range(99) >= 31)) begin
      held_word = pending_words.pop_front();
      word_held = 1;
    end
    in_ch.valid <= word_held;
    in_ch.mode <= held_word.drain;
    in_ch.pixel_bytes <= held_word.px;
  end

  // Receiver: stalls at random, or for a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  task automatic wait_idle();
    send_pause = 0;
    while (pending_words.size() > 0 || word_held || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == CfgImageWidth) cur_width = val & 16'h1FFF;
    else cur_height = val;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_word(bit drain, bit [31:0] px);
    pix_word_t w;
    w.drain = drain;
    w.px = px;
    pending_words = {pending_words, w};
    words_added++;
  endtask

  // Drains whatever is left of a pending row so that a new width starts clean.
  task automatic flush_row();
    int unsigned n;
    if (row_waiting && row_idx == 0) begin
      n = eff_width() - col_idx;
      for (int i = 0; i < n; i++) add_word(1, $urandom);
      wait_idle();
    end
  endtask

  // One image: smooth or random content, stray drains, then a full or partial drain of the last row.
  task automatic add_image(int unsigned w, int unsigned h, bit partial_drain);
    bit [31:0] base = $urandom;
    bit        smooth = $urandom_range(1);
    int        n;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(99) < 4) add_word(1, $urandom);
        if (smooth) begin
          for (int l = 0; l < LaneCount; l++) base[l*8 +: 8] += 8'($urandom_range(6)) - 8'd3;
          add_word(0, base);
        end else begin
          add_word(0, $urandom);
        end
      end
    end
    n = partial_drain ? $urandom_range(w - 1) : w;
    for (int i = 0; i < n; i++) add_word(1, $urandom);
  endtask

  int unsigned rw, rh, nimg;

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.pixel_bytes = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgImageWidth;
    cfg_ch.data = '0;
    held_word.drain = 0;
    held_word.px = 0;
    for (int f = 0; f < NumFilters; f++) cost_sum[f] = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a drain with nothing to flush, then extreme bytes on a 1x1 image.
    add_word(1, 32'hFFFF_FFFF);
    add_word(0, 32'h0000_0000);
    add_word(0, 32'hFFFF_FFFF);
    add_word(0, 32'h8080_8080);
    add_word(0, 32'h7F7F_7F7F);
    add_word(0, 32'h0180_7FFE);
    add_word(1, 32'h0);
    add_word(1, 32'h0);
    wait_idle();

    // Zero width and height act as one.
    write_reg(CfgImageWidth, 16'd0);
    write_reg(CfgImageHeight, 16'd0);
    add_word(0, 32'h1234_5678);
    add_word(0, 32'hFEDC_BA98);
    add_word(1, 32'h0);
    wait_idle();

    // Small image with gradients, and a pixel that follows a partial drain.
    write_reg(CfgImageWidth, 16'd4);
    write_reg(CfgImageHeight, 16'd3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) add_word(0, {4{8'(r * 40 + c * 9)}});
    add_word(1, 0);
    add_word(1, 0);
    add_word(0, 32'hA5A5_A5A5);
    add_word(1, 0);
    wait_idle();

    // A long stretch with no idling on either side.
    write_reg(CfgImageWidth, 16'd20);
    write_reg(CfgImageHeight, 16'd3);
    no_idle = 1;
    add_image(20, 3, 0);
    wait_idle();
    no_idle = 0;

    // Output held off while the sender streams on, so the input stalls.
    write_reg(CfgImageWidth, 16'd8);
    write_reg(CfgImageHeight, 16'd3);
    no_idle = 1;
    rx_hold_cycles = 300;
    add_image(8, 3, 0);
    wait_idle();
    no_idle = 0;

    // Sender pauses mid-image until every expected word is back.
    add_image(8, 3, 0);
    while (pending_words.size() > 16) @(posedge clk_i);
    send_pause = 1;
    while (word_held || expected_pixels.size() > 0) @(posedge clk_i);
    wait_idle();

    // Random images of small sizes.
    while (words_added < 420) begin
      rw = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      rh = $urandom_range(1, 4);
      write_reg(CfgImageWidth, 16'(rw) | 16'($urandom_range(7) << 13));
      write_reg(CfgImageHeight, 16'(rh));
      nimg = $urandom_range(1, 2);
      for (int i = 0; i < nimg; i++) begin
        add_image(rw, rh, $urandom_range(9) == 0);
      end
      wait_idle();
      flush_row();
    end

    // Tallest image: a few rows only, never finished.
    write_reg(CfgImageWidth, 16'd2);
    write_reg(CfgImageHeight, 16'hFFFF);
    for (int i = 0; i < 20; i++) add_word(0, $urandom);
    add_word(1, $urandom);
    wait_idle();

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
